/* design/vdp_pkg.sv */
// Package: shared types, constants and helpers for the video DAC palette register block.
package vdp_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int LANES           = 3;

    localparam logic [PAL_AW-1:0] PAL_ADDR_ONE  = PAL_AW'(1);
    localparam logic [PAL_AW-1:0] PAL_ADDR_LAST = PAL_AW'(PALETTE_ENTRIES - 1);

    localparam logic [7:0] MODE_BLANK_BIT = 8'h80;
    localparam logic [7:0] DAC_CTRL_MASK  = 8'h7F;
    localparam logic [2:0] STRAP_RESET    = 3'h6;

    typedef enum logic [1:0] {
        FUNC_READ   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    // Video control window offsets; 4..7 are beam counters.
    typedef enum logic [2:0] {
        CTL_MODE  = 3'd0,
        CTL_DEPTH = 3'd1,
        CTL_SENSE = 3'd2,
        CTL_TEST  = 3'd3,
        CTL_BEAM0 = 3'd4,
        CTL_BEAM1 = 3'd5,
        CTL_BEAM2 = 3'd6,
        CTL_BEAM3 = 3'd7
    } t_ctl_off;

    // Palette DAC window offsets (low two bits of reg_offset).
    typedef enum logic [1:0] {
        DAC_ADDR = 2'd0,
        DAC_DATA = 2'd1,
        DAC_CTRL = 2'd2,
        DAC_KEY  = 2'd3
    } t_dac_off;

    typedef enum logic [2:0] {
        DEPTH_1BPP   = 3'd0,
        DEPTH_2BPP   = 3'd1,
        DEPTH_4BPP   = 3'd2,
        DEPTH_DIRECT = 3'd4
    } t_depth;

    typedef enum logic [1:0] {
        LANE_RED   = 2'd0,
        LANE_GREEN = 2'd1,
        LANE_BLUE  = 2'd2
    } t_lane;

    typedef struct packed {
        logic [1:0] func;
        logic       window_select;
        logic [2:0] reg_offset;
        logic [7:0] write_byte;
        logic [7:0] pixel_value;
    } t_req;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       palette_bypassed;
        logic       display_blanked;
    } t_res;

    // One palette access per request: per-lane read and write enables.
    typedef struct packed {
        logic [LANES-1:0]  re;
        logic [LANES-1:0]  we;
        logic [PAL_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_cmd;

    // What the result stage needs from the decoded request.
    typedef struct packed {
        logic       data_read;
        t_lane      slot;
        logic [7:0] rd_byte;
        logic       lookup;
        logic       bypass;
        logic       blanked;
    } t_s1_info;

    function automatic logic mode_has_timing(input logic [7:0] mode);
        logic ok;
        case (mode[4:0])
            5'd1, 5'd2, 5'd6, 5'd9, 5'd11, 5'd13: ok = 1'b1;
            default:                             ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Depth-windowed index: low pixel bits on top, rest ones; other codes: whole pixel.
    function automatic logic [PAL_AW-1:0] lookup_index(input logic [2:0] code,
                                                       input logic [7:0] pix);
        logic [PAL_AW-1:0] idx;
        case (code)
            DEPTH_1BPP: idx = {pix[0],   7'h7F};
            DEPTH_2BPP: idx = {pix[1:0], 6'h3F};
            DEPTH_4BPP: idx = {pix[3:0], 4'hF};
            default:    idx = pix;
        endcase
        return idx;
    endfunction

endpackage

/* design/vdp_clut_lane.sv */
// One color lane of the palette store: 256 x 8 memory with a registered read port.
module vdp_clut_lane (
    input  logic                       i_clk,
    input  logic                       i_re,
    input  logic                       i_we,
    input  logic [vdp_pkg::PAL_AW-1:0] i_addr,
    input  logic [7:0]                 i_wdata,
    output logic [7:0]                 o_rdata
);

    logic [7:0] r_mem [vdp_pkg::PALETTE_ENTRIES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rd_data;

endmodule

/* design/vdp_reg_file.sv */
// Register file and request decode for the control and palette DAC windows.
module vdp_reg_file (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  vdp_pkg::t_req     i_req,
    input  logic [2:0]        i_strap,
    output vdp_pkg::t_mem_cmd o_mem,
    output vdp_pkg::t_s1_info o_info
);

    logic [7:0]              r_mode, r_depth, r_sense, r_test, r_ctrl, r_key;
    logic [vdp_pkg::PAL_AW-1:0] r_addr;
    logic [1:0]              r_phase;

    logic [7:0]              n_mode, n_depth, n_sense, n_test, n_ctrl, n_key;
    logic [vdp_pkg::PAL_AW-1:0] n_addr;
    logic [1:0]              n_phase;

    logic [1:0]              step_phase;
    logic [vdp_pkg::PAL_AW-1:0] step_addr;
    vdp_pkg::t_lane          slot;
    logic [vdp_pkg::LANES-1:0] slot_oh;
    logic [7:0]              sense_rd;

    always_comb begin
        // Phase three never occurs; treat it as blue.
        slot = (r_phase >= 2'd2) ? vdp_pkg::LANE_BLUE : vdp_pkg::t_lane'(r_phase);
        case (slot)
            vdp_pkg::LANE_RED:   slot_oh = 3'b001;
            vdp_pkg::LANE_GREEN: slot_oh = 3'b010;
            default:             slot_oh = 3'b100;
        endcase

        step_phase = r_phase + 2'd1;
        step_addr  = r_addr;
        if (step_phase == 2'd3) begin
            step_phase = 2'd0;
            step_addr  = r_addr + vdp_pkg::PAL_ADDR_ONE;
        end

        sense_rd = {1'b0, r_sense[2:0] & i_strap, r_sense[3:0]};
    end

    always_comb begin
        n_mode  = r_mode;
        n_depth = r_depth;
        n_sense = r_sense;
        n_test  = r_test;
        n_ctrl  = r_ctrl;
        n_key   = r_key;
        n_addr  = r_addr;
        n_phase = r_phase;

        o_mem.re    = '0;
        o_mem.we    = '0;
        o_mem.addr  = r_addr;
        o_mem.wdata = i_req.write_byte;

        o_info.data_read = 1'b0;
        o_info.slot      = slot;
        o_info.rd_byte   = 8'h00;
        o_info.lookup    = 1'b0;
        o_info.bypass    = 1'b0;
        o_info.blanked   = 1'b0;

        case (vdp_pkg::t_func'(i_req.func))
            vdp_pkg::FUNC_READ: begin
                if (i_req.window_select) begin
                    case (vdp_pkg::t_dac_off'(i_req.reg_offset[1:0]))
                        vdp_pkg::DAC_ADDR: o_info.rd_byte = r_addr;
                        vdp_pkg::DAC_DATA: begin
                            o_info.data_read = 1'b1;
                            o_mem.re         = slot_oh;
                            n_addr           = step_addr;
                            n_phase          = step_phase;
                        end
                        vdp_pkg::DAC_CTRL: o_info.rd_byte = r_ctrl & vdp_pkg::DAC_CTRL_MASK;
                        default:           o_info.rd_byte = r_key;
                    endcase
                end else begin
                    case (vdp_pkg::t_ctl_off'(i_req.reg_offset))
                        vdp_pkg::CTL_MODE:  o_info.rd_byte = r_mode;
                        vdp_pkg::CTL_DEPTH: o_info.rd_byte = r_depth;
                        vdp_pkg::CTL_SENSE: o_info.rd_byte = sense_rd;
                        vdp_pkg::CTL_TEST:  o_info.rd_byte = r_test;
                        default:            o_info.rd_byte = 8'h00;
                    endcase
                end
            end
            vdp_pkg::FUNC_WRITE: begin
                if (i_req.window_select) begin
                    case (vdp_pkg::t_dac_off'(i_req.reg_offset[1:0]))
                        vdp_pkg::DAC_ADDR: begin
                            n_addr  = i_req.write_byte;
                            n_phase = 2'd0;
                        end
                        vdp_pkg::DAC_DATA: begin
                            o_mem.we = slot_oh;
                            n_addr   = step_addr;
                            n_phase  = step_phase;
                        end
                        vdp_pkg::DAC_CTRL: n_ctrl = i_req.write_byte;
                        default:           n_key  = i_req.write_byte;
                    endcase
                end else begin
                    case (vdp_pkg::t_ctl_off'(i_req.reg_offset))
                        vdp_pkg::CTL_MODE:  n_mode  = i_req.write_byte;
                        vdp_pkg::CTL_DEPTH: n_depth = i_req.write_byte;
                        vdp_pkg::CTL_SENSE: n_sense = i_req.write_byte;
                        vdp_pkg::CTL_TEST:  n_test  = i_req.write_byte;
                        default:            ;
                    endcase
                end
            end
            vdp_pkg::FUNC_LOOKUP: begin
                o_info.lookup  = 1'b1;
                o_info.blanked = ((r_mode & vdp_pkg::MODE_BLANK_BIT) != 8'h00)
                                 || !vdp_pkg::mode_has_timing(r_mode);
                if (r_depth[2:0] == vdp_pkg::DEPTH_DIRECT) begin
                    o_info.bypass = 1'b1;
                end else begin
                    o_mem.re   = '1;
                    o_mem.addr = vdp_pkg::lookup_index(r_depth[2:0], i_req.pixel_value);
                end
            end
            default: ;
        endcase

        // Only an accepted request touches state or memory.
        if (!i_accept) begin
            o_mem.re = '0;
            o_mem.we = '0;
            n_mode   = r_mode;
            n_depth  = r_depth;
            n_sense  = r_sense;
            n_test   = r_test;
            n_ctrl   = r_ctrl;
            n_key    = r_key;
            n_addr   = r_addr;
            n_phase  = r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 8'h00;
            r_depth <= 8'h00;
            r_sense <= 8'h00;
            r_test  <= 8'h00;
            r_ctrl  <= 8'h00;
            r_key   <= 8'h00;
            r_addr  <= '0;
            r_phase <= 2'd0;
        end else begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_sense <= n_sense;
            r_test  <= n_test;
            r_ctrl  <= n_ctrl;
            r_key   <= n_key;
            r_addr  <= n_addr;
            r_phase <= n_phase;
        end
    end

endmodule

/* design/video_dac_palette_registers.sv */
// Top level: video control and palette DAC register block with palette lookup.
// Path: palette read and stage-one registers, then the result register that drives o_done.
// Throughput: one request per cycle once the palette is cleared; busy then stays low.
// Reset (synchronous, active low) clears the control and DAC registers and sets the strap
// to 6; after release, busy holds while one pass writes zero to every palette entry.
// Results cannot be stalled: each is shown for exactly one cycle with o_done.
module video_dac_palette_registers (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  vdp_pkg::t_req i_req,
    output logic          o_done,
    output vdp_pkg::t_res o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_data
);

    logic              accept;
    logic [2:0]        r_strap;
    vdp_pkg::t_mem_cmd mem_cmd;
    vdp_pkg::t_mem_cmd lane_cmd;
    vdp_pkg::t_s1_info info;
    vdp_pkg::t_s1_info r_s1_info;
    logic              r_s1_valid;
    logic [7:0]        lane_rd [vdp_pkg::LANES];
    logic              r_out_valid;
    vdp_pkg::t_res     r_res;
    vdp_pkg::t_res     n_res;
    logic              r_clearing;
    logic [vdp_pkg::PAL_AW-1:0] r_clr_addr;

    // Hold off requests only while the palette is being cleared.
    assign busy        = r_clearing;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Clear pass: walk every palette entry once after reset, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + vdp_pkg::PAL_ADDR_ONE;
            if (r_clr_addr == vdp_pkg::PAL_ADDR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Hold the sense strap; the user writes it only while idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strap <= vdp_pkg::STRAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_strap <= i_cfg_data;
        end
    end

    // Decode the request and update register state at the accepting edge.
    vdp_reg_file u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_req   (i_req),
        .i_strap (r_strap),
        .o_mem   (mem_cmd),
        .o_info  (info)
    );

    // Steer the palette port to the clear pass until it is done.
    always_comb begin
        lane_cmd = mem_cmd;
        if (r_clearing) begin
            lane_cmd.re    = '0;
            lane_cmd.we    = '1;
            lane_cmd.addr  = r_clr_addr;
            lane_cmd.wdata = 8'h00;
        end
    end

    // Palette store: one lane per color, sharing one address.
    for (genvar g = 0; g < vdp_pkg::LANES; g++) begin : g_lane
        vdp_clut_lane u_lane (
            .i_clk  (i_clk),
            .i_re   (lane_cmd.re[g]),
            .i_we   (lane_cmd.we[g]),
            .i_addr (lane_cmd.addr),
            .i_wdata(lane_cmd.wdata),
            .o_rdata(lane_rd[g])
        );
    end

    // Stage one: hold the decoded request next to the registered palette data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= info;
        end
    end

    // Assemble the result: data-port reads pick one lane, lookups that do not bypass take all three.
    always_comb begin
        n_res                  = '0;
        n_res.read_byte        = r_s1_info.rd_byte;
        n_res.palette_bypassed = r_s1_info.bypass;
        n_res.display_blanked  = r_s1_info.blanked;
        if (r_s1_info.data_read) begin
            case (r_s1_info.slot)
                vdp_pkg::LANE_RED:   n_res.read_byte = lane_rd[vdp_pkg::LANE_RED];
                vdp_pkg::LANE_GREEN: n_res.read_byte = lane_rd[vdp_pkg::LANE_GREEN];
                default:             n_res.read_byte = lane_rd[vdp_pkg::LANE_BLUE];
            endcase
        end
        if (r_s1_info.lookup && !r_s1_info.bypass) begin
            n_res.red   = lane_rd[vdp_pkg::LANE_RED];
            n_res.green = lane_rd[vdp_pkg::LANE_GREEN];
            n_res.blue  = lane_rd[vdp_pkg::LANE_BLUE];
        end
    end

    // Result register: strobe for one cycle per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_out_valid;
    assign o_res  = r_res;

endmodule

/* sim/testbench.sv */
// Testbench: self-checking random and directed run of the video DAC palette register block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vdp_pkg::*;

    // Give up long after the slowest correct run could have finished.
    localparam int LIMIT_CYCLES = 200000;
    // Margin for the pipeline once the response queue is empty.
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       o_done;
    t_res       o_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_data;

    // Mode codes that carry a timing set; the rest blank the display.
    logic [4:0] timed_modes [6] = '{5'd1, 5'd2, 5'd6, 5'd9, 5'd11, 5'd13};

    // Register image kept by the testbench, updated at each accepted request.
    logic [7:0] palette [PALETTE_ENTRIES][LANES];
    logic [7:0] m_pal_addr;
    logic [1:0] m_phase;
    logic [7:0] m_dac_ctrl;
    logic [7:0] m_key;
    logic [7:0] m_mode;
    logic [7:0] m_depth;
    logic [7:0] m_drive;
    logic [7:0] m_test;
    logic [2:0] m_strap;

    t_res pending_responses[$];
    int   error_count = 0;
    int   cycle_count = 0;
    bit   idle_on;

    video_dac_palette_registers uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Step the data port: red, green, blue, then the next address.
    task automatic advance_color_phase();
        m_phase = m_phase + 2'd1;
        if (m_phase == 2'd3) begin
            m_phase    = 2'd0;
            m_pal_addr = m_pal_addr + 8'd1;
        end
    endtask

    // Apply one request to the register image and work out the response it gives.
    task automatic predict_response(input t_req r, output t_res e);
        logic [2:0] code;
        int         bits;
        int         skip;
        int         idx;
        t_lane      slot;
        e    = '0;
        // A phase past blue would act as blue.
        slot = (m_phase >= LANE_BLUE) ? LANE_BLUE : t_lane'(m_phase);
        case (r.func)
            FUNC_READ: begin
                if (!r.window_select) begin
                    case (r.reg_offset)
                        CTL_MODE:  e.read_byte = m_mode;
                        CTL_DEPTH: e.read_byte = m_depth;
                        // Drive nibble below, sense lines (drive AND strap) in 6:4.
                        CTL_SENSE: e.read_byte = {1'b0, m_drive[2:0] & m_strap, m_drive[3:0]};
                        CTL_TEST:  e.read_byte = m_test;
                        default:   e.read_byte = 8'h00;   // beam counters
                    endcase
                end else begin
                    case (r.reg_offset[1:0])
                        DAC_ADDR: e.read_byte = m_pal_addr;
                        DAC_DATA: begin
                            e.read_byte = palette[m_pal_addr][slot];
                            advance_color_phase();
                        end
                        DAC_CTRL: e.read_byte = m_dac_ctrl & DAC_CTRL_MASK;
                        default:  e.read_byte = m_key;
                    endcase
                end
            end
            FUNC_WRITE: begin
                if (!r.window_select) begin
                    case (r.reg_offset)
                        CTL_MODE:  m_mode  = r.write_byte;
                        CTL_DEPTH: m_depth = r.write_byte;
                        CTL_SENSE: m_drive = r.write_byte;
                        CTL_TEST:  m_test  = r.write_byte;
                        default:   ;                       // beam counters ignore writes
                    endcase
                end else begin
                    case (r.reg_offset[1:0])
                        DAC_ADDR: begin
                            m_pal_addr = r.write_byte;
                            m_phase    = 2'd0;
                        end
                        DAC_DATA: begin
                            palette[m_pal_addr][slot] = r.write_byte;
                            advance_color_phase();
                        end
                        DAC_CTRL: m_dac_ctrl = r.write_byte;
                        default:  m_key      = r.write_byte;
                    endcase
                end
            end
            FUNC_LOOKUP: begin
                code = m_depth[2:0];
                e.display_blanked = ((m_mode & MODE_BLANK_BIT) != 8'h00) ||
                                    !(m_mode[4:0] inside {5'd1, 5'd2, 5'd6, 5'd9, 5'd11, 5'd13});
                if (code == DEPTH_DIRECT) begin
                    // Direct colour skips the palette; color fields stay zero.
                    e.palette_bypassed = 1'b1;
                end else begin
                    case (code)
                        DEPTH_1BPP: bits = 1;
                        DEPTH_2BPP: bits = 2;
                        DEPTH_4BPP: bits = 4;
                        default:    bits = 8;
                    endcase
                    // Spread the pixel over the palette; entries below end in all ones.
                    skip = PALETTE_ENTRIES >> bits;
                    idx  = ((skip - 1) + (r.pixel_value & ((1 << bits) - 1)) * skip)
                           % PALETTE_ENTRIES;
                    e.red   = palette[idx][LANE_RED];
                    e.green = palette[idx][LANE_GREEN];
                    e.blue  = palette[idx][LANE_BLUE];
                end
            end
            default: ;                                     // unused kind: no effect
        endcase
    endtask

    // Track reset, strap writes and accepted requests at each edge; sample pre-edge values.
    always @(posedge i_clk) begin : track_requests
        t_res want;
        if (!i_rst_n) begin
            foreach (palette[a, l]) palette[a][l] = 8'h00;
            m_pal_addr = 8'h00;
            m_phase    = 2'd0;
            m_dac_ctrl = 8'h00;
            m_key      = 8'h00;
            m_mode     = 8'h00;
            m_depth    = 8'h00;
            m_drive    = 8'h00;
            m_test     = 8'h00;
            m_strap    = STRAP_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) m_strap = i_cfg_data;
            if (start && !busy) begin
                predict_response(i_req, want);
                pending_responses.push_back(want);
            end
        end
    end

    // Compare every strobed response with the oldest expectation, field by field.
    always @(posedge i_clk) begin : check_responses
        t_res want;
        if (i_rst_n && o_done) begin
            if (pending_responses.size() == 0) begin
                $error("response strobed with nothing expected: %h", o_res);
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                if (o_res.read_byte !== want.read_byte) begin
                    $error("read_byte: expected %0h, actual %0h", want.read_byte, o_res.read_byte);
                    error_count++;
                end
                if (o_res.red !== want.red) begin
                    $error("red: expected %0h, actual %0h", want.red, o_res.red);
                    error_count++;
                end
                if (o_res.green !== want.green) begin
                    $error("green: expected %0h, actual %0h", want.green, o_res.green);
                    error_count++;
                end
                if (o_res.blue !== want.blue) begin
                    $error("blue: expected %0h, actual %0h", want.blue, o_res.blue);
                    error_count++;
                end
                if (o_res.palette_bypassed !== want.palette_bypassed) begin
                    $error("palette_bypassed: expected %0b, actual %0b",
                           want.palette_bypassed, o_res.palette_bypassed);
                    error_count++;
                end
                if (o_res.display_blanked !== want.display_blanked) begin
                    $error("display_blanked: expected %0b, actual %0b",
                           want.display_blanked, o_res.display_blanked);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic t_req bus_request(input t_func f, input logic win,
                                         input logic [2:0] off, input logic [7:0] wb,
                                         input logic [7:0] pix);
        t_req r;
        r.func          = f;
        r.window_select = win;
        r.reg_offset    = off;
        r.write_byte    = wb;
        r.pixel_value   = pix;
        return r;
    endfunction

    // Present one request, maybe after an idle burst; hold start high until accepted.
    task automatic issue_request(input t_req r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drop start and hold off until every expected response has come out.
    task automatic wait_for_responses();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the strap register while the block is idle.
    task automatic set_sense_strap(input logic [2:0] value);
        wait_for_responses();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        issue_request(bus_request(FUNC_READ, 1'b0, CTL_MODE, rand_byte(), rand_byte()));
        issue_request(bus_request(FUNC_READ, 1'b0, CTL_SENSE, rand_byte(), rand_byte()));
        issue_request(bus_request(FUNC_READ, 1'b0, CTL_BEAM3, rand_byte(), rand_byte()));
        issue_request(bus_request(FUNC_READ, 1'b1, {1'b0, DAC_DATA}, rand_byte(), rand_byte()));
        issue_request(bus_request(FUNC_READ, 1'b1, {1'b0, DAC_KEY}, rand_byte(), rand_byte()));
        issue_request(bus_request(FUNC_LOOKUP, 1'b0, CTL_MODE, rand_byte(), 8'hFF));
    endtask

    task automatic test_control_window();
        issue_request(bus_request(FUNC_WRITE, 1'b0, CTL_MODE, 8'hFF, rand_byte()));
        issue_request(bus_request(FUNC_WRITE, 1'b0, CTL_SENSE, 8'hFF, rand_byte()));
        issue_request(bus_request(FUNC_WRITE, 1'b0, CTL_TEST, 8'h00, rand_byte()));
        // Beam counters drop writes and read zero.
        issue_request(bus_request(FUNC_WRITE, 1'b0, CTL_BEAM1, 8'hFF, rand_byte()));
        issue_request(bus_request(FUNC_READ, 1'b0, CTL_BEAM1, rand_byte(), rand_byte()));
        issue_request(bus_request(FUNC_READ, 1'b0, CTL_MODE, rand_byte(), rand_byte()));
        issue_request(bus_request(FUNC_READ, 1'b0, CTL_TEST, rand_byte(), rand_byte()));
    endtask

    // With the drive all ones, the sense lines follow the strap.
    task automatic test_sense_strap();
        set_sense_strap(3'h0);
        issue_request(bus_request(FUNC_READ, 1'b0, CTL_SENSE, rand_byte(), rand_byte()));
        set_sense_strap(3'h7);
        issue_request(bus_request(FUNC_READ, 1'b0, CTL_SENSE, rand_byte(), rand_byte()));
    endtask

    task automatic test_palette_port();
        // Fill the last entry, then let the address wrap to zero.
        issue_request(bus_request(FUNC_WRITE, 1'b1, {1'b0, DAC_ADDR}, 8'hFF, rand_byte()));
        issue_request(bus_request(FUNC_WRITE, 1'b1, {1'b0, DAC_DATA}, 8'hFF, rand_byte()));
        issue_request(bus_request(FUNC_WRITE, 1'b1, {1'b0, DAC_DATA}, 8'h00, rand_byte()));
        issue_request(bus_request(FUNC_WRITE, 1'b1, {1'b0, DAC_DATA}, 8'hA5, rand_byte()));
        issue_request(bus_request(FUNC_WRITE, 1'b1, {1'b0, DAC_DATA}, 8'h5A, rand_byte()));
        issue_request(bus_request(FUNC_READ, 1'b1, {1'b0, DAC_ADDR}, rand_byte(), rand_byte()));
        // An address write mid-triple restarts at red; offset bit 2 is don't-care.
        issue_request(bus_request(FUNC_WRITE, 1'b1, {1'b1, DAC_ADDR}, 8'hFF, rand_byte()));
        repeat (3)
            issue_request(bus_request(FUNC_READ, 1'b1, {1'b0, DAC_DATA}, rand_byte(),
                                      rand_byte()));
        issue_request(bus_request(FUNC_WRITE, 1'b1, {1'b0, DAC_CTRL}, 8'hFF, rand_byte()));
        issue_request(bus_request(FUNC_READ, 1'b1, {1'b0, DAC_CTRL}, rand_byte(), rand_byte()));
        issue_request(bus_request(FUNC_WRITE, 1'b1, {1'b0, DAC_KEY}, 8'h80, rand_byte()));
        issue_request(bus_request(FUNC_READ, 1'b1, {1'b1, DAC_KEY}, rand_byte(), rand_byte()));
    endtask

    task automatic test_lookup_depths();
        issue_request(bus_request(FUNC_WRITE, 1'b0, CTL_MODE, 8'h01, rand_byte()));
        // Walk every depth code; outside direct mode, an all-ones pixel lands on the filled last entry.
        for (int c = 0; c < 8; c++) begin
            issue_request(bus_request(FUNC_WRITE, 1'b0, CTL_DEPTH, {5'h1F, 3'(c)}, rand_byte()));
            issue_request(bus_request(FUNC_LOOKUP, 1'b1, CTL_MODE, rand_byte(), 8'hFF));
        end
        // Blank bit set, then a mode code with no timing: entry still reported.
        issue_request(bus_request(FUNC_WRITE, 1'b0, CTL_MODE, 8'h81, rand_byte()));
        issue_request(bus_request(FUNC_LOOKUP, 1'b0, CTL_MODE, rand_byte(), 8'h00));
        issue_request(bus_request(FUNC_WRITE, 1'b0, CTL_MODE, 8'h00, rand_byte()));
        issue_request(bus_request(FUNC_LOOKUP, 1'b0, CTL_MODE, rand_byte(), 8'hFF));
        issue_request(bus_request(FUNC_NONE, 1'b1, CTL_MODE, 8'hFF, 8'hFF));
    endtask

    // One random burst: mostly well-formed palette and lookup sequences, some noise.
    task automatic run_random_sequence(inout int issued);
        int         kind;
        int         n;
        logic [7:0] mode;
        logic [2:0] off;
        t_req       r;
        kind = $urandom_range(0, 9);
        n    = $urandom_range(1, 12);
        case (kind)
            0, 1, 2: begin
                issue_request(bus_request(FUNC_WRITE, 1'b1, {1'($urandom), DAC_ADDR},
                                          rand_byte(), rand_byte()));
                repeat (n)
                    issue_request(bus_request(FUNC_WRITE, 1'b1, {1'($urandom), DAC_DATA},
                                              rand_byte(), rand_byte()));
                issued += n + 1;
            end
            3, 4: begin
                issue_request(bus_request(FUNC_WRITE, 1'b1, {1'($urandom), DAC_ADDR},
                                          rand_byte(), rand_byte()));
                repeat (n) begin
                    off = ($urandom_range(0, 3) == 0) ? 3'($urandom) : {1'($urandom), DAC_DATA};
                    issue_request(bus_request(t_func'($urandom_range(0, 1)), 1'b1, off,
                                              rand_byte(), rand_byte()));
                end
                issued += n + 1;
            end
            5, 6: begin
                if ($urandom_range(0, 1) == 1) begin
                    issue_request(bus_request(FUNC_WRITE, 1'b0, CTL_DEPTH, rand_byte(),
                                              rand_byte()));
                    issued++;
                end
                if ($urandom_range(0, 1) == 1) begin
                    mode = rand_byte();
                    if ($urandom_range(0, 2) != 0) mode[4:0] = timed_modes[$urandom_range(0, 5)];
                    issue_request(bus_request(FUNC_WRITE, 1'b0, CTL_MODE, mode, rand_byte()));
                    issued++;
                end
                repeat (n)
                    issue_request(bus_request(FUNC_LOOKUP, 1'($urandom), 3'($urandom),
                                              rand_byte(), rand_byte()));
                issued += n;
            end
            7: begin
                repeat (n)
                    issue_request(bus_request(t_func'($urandom_range(0, 1)), 1'b0, 3'($urandom),
                                              rand_byte(), rand_byte()));
                issued += n;
            end
            default: begin
                repeat (n) begin
                    r = bus_request(t_func'($urandom_range(0, 3)), 1'($urandom), 3'($urandom),
                                    rand_byte(), rand_byte());
                    issue_request(r);
                    if (r.func != FUNC_NONE) issued++;
                end
            end
        endcase
    endtask

    // Random phases, each behind a drain and a strap write; the last ones run without gaps.
    task automatic test_random_traffic();
        int issued;
        for (int ph = 0; ph < PHASES; ph++) begin
            set_sense_strap((ph == 0) ? 3'h0 : (ph == 1) ? 3'h7 : 3'($urandom));
            idle_on = (ph < PHASES - 2);
            issued  = 0;
            while (issued < PHASE_ITEMS) run_random_sequence(issued);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= STRAP_RESET;
        idle_on      = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_control_window();
        test_sense_strap();
        test_palette_port();
        test_lookup_depths();
        test_random_traffic();

        wait_for_responses();
        if (error_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
